// File: rtl/s5req_pkg.sv
// shared types, codes and constants of the socks5 request byte parser
// no dependencies; imported by every module under rtl
package s5req_pkg;

   // protocol constants
   localparam logic [7:0] SOCKS_VERSION = 8'h05;
   localparam logic [7:0] RSV_VALUE     = 8'h00;
   localparam logic [7:0] LEN_IPV4      = 8'd4;
   localparam logic [7:0] LEN_IPV6      = 8'd16;

   // command codes
   localparam logic [7:0] CMD_CONNECT   = 8'd1;
   localparam logic [7:0] CMD_UDP_ASSOC = 8'd3;

   // address type codes
   localparam logic [2:0] ATYP_IPV4   = 3'd1;
   localparam logic [2:0] ATYP_DOMAIN = 3'd3;
   localparam logic [2:0] ATYP_IPV6   = 3'd4;

   // number of port bytes on the wire
   localparam logic [1:0] PORT_BYTES = 2'd2;

   typedef enum logic [3:0] {
      PHASE_VER        = 4'd0,
      PHASE_CMD        = 4'd1,
      PHASE_RSV        = 4'd2,
      PHASE_ATYP       = 4'd3,
      PHASE_ADDR       = 4'd4,
      PHASE_PORT       = 4'd5,
      PHASE_OK         = 4'd6,
      PHASE_BADVER     = 4'd7,
      PHASE_BADCMD     = 4'd8,
      PHASE_BADRSV     = 4'd9,
      PHASE_BADATYP    = 4'd10,
      PHASE_BADDOMAIN  = 4'd11
   } phase_type;

   // parser state carried from beat to beat
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  cmd;
      logic [2:0]  atyp;
      logic [7:0]  addr_len;
      logic [7:0]  addr_count;
      logic [1:0]  port_count;
      logic [15:0] port;
   } state_type;

   // one result beat
   typedef struct packed {
      logic [3:0]  parse_status;
      logic        done_res;
      logic        errored;
      logic [1:0]  command_code;
      logic [2:0]  address_kind;
      logic [7:0]  address_length;
      logic        addr_byte_valid;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_position;
      logic [15:0] dest_port;
   } rsp_type;

endpackage

// File: rtl/s5req_step.sv
// next-state and result logic for one request byte
// depends on s5req_pkg
module s5req_step (
   input  s5req_pkg::state_type cur_state,
   input  logic [7:0]           data_byte,
   input  logic                 restart,
   output s5req_pkg::state_type next_state,
   output s5req_pkg::rsp_type   rsp
);
   import s5req_pkg::*;

   logic       atyp_fixed;
   logic       len_known;
   logic [7:0] len_eff;
   logic [7:0] count_eff;
   logic [7:0] count_inc;
   logic [1:0] port_count_inc;
   logic       cmd_ok;
   logic       atyp_ok;
   phase_type  phase_in;
   logic       avalid;

   // address phase helpers
   assign atyp_fixed = (cur_state.atyp == ATYP_IPV4) || (cur_state.atyp == ATYP_IPV6);
   assign len_known  = (cur_state.addr_len != 8'd0);
   always_comb begin
      len_eff   = cur_state.addr_len;
      count_eff = cur_state.addr_count;
      if (atyp_fixed && !len_known) begin
         len_eff   = (cur_state.atyp == ATYP_IPV4) ? LEN_IPV4 : LEN_IPV6;
         count_eff = 8'd0;
      end
   end
   assign count_inc      = count_eff + 8'd1;
   assign port_count_inc = cur_state.port_count + 2'd1;
   assign cmd_ok  = (data_byte >= CMD_CONNECT) && (data_byte <= CMD_UDP_ASSOC);
   assign atyp_ok = (data_byte == {5'd0, ATYP_IPV4}) || (data_byte == {5'd0, ATYP_DOMAIN})
                 || (data_byte == {5'd0, ATYP_IPV6});

   // next phase
   always_comb begin
      phase_in = cur_state.phase;
      if (restart) begin
         phase_in = PHASE_VER;
      end else begin
         unique case (cur_state.phase)
            PHASE_VER: begin
               phase_in = (data_byte == SOCKS_VERSION) ? PHASE_CMD : PHASE_BADVER;
            end
            PHASE_CMD: begin
               phase_in = cmd_ok ? PHASE_RSV : PHASE_BADCMD;
            end
            PHASE_RSV: begin
               phase_in = (data_byte == RSV_VALUE) ? PHASE_ATYP : PHASE_BADRSV;
            end
            PHASE_ATYP: begin
               phase_in = atyp_ok ? PHASE_ADDR : PHASE_BADATYP;
            end
            PHASE_ADDR: begin
               if (atyp_fixed || (cur_state.atyp == ATYP_DOMAIN && len_known)) begin
                  if (count_inc == len_eff) phase_in = PHASE_PORT;
               end else if (cur_state.atyp == ATYP_DOMAIN) begin
                  if (data_byte == 8'd0) phase_in = PHASE_BADDOMAIN;
               end else begin
                  phase_in = PHASE_BADATYP;
               end
            end
            PHASE_PORT: begin
               if (port_count_inc == PORT_BYTES) phase_in = PHASE_OK;
            end
            default: phase_in = cur_state.phase;
         endcase
      end
   end

   // datapath state and address byte output
   always_comb begin
      next_state       = cur_state;
      next_state.phase = phase_in;
      avalid           = 1'b0;
      if (restart) begin
         next_state = '0;
         next_state.phase = PHASE_VER;
      end else begin
         unique case (cur_state.phase)
            PHASE_CMD: begin
               if (cmd_ok) next_state.cmd = data_byte[1:0];
            end
            PHASE_ATYP: begin
               if (atyp_ok) next_state.atyp = data_byte[2:0];
            end
            PHASE_ADDR: begin
               if (atyp_fixed || (cur_state.atyp == ATYP_DOMAIN && len_known)) begin
                  avalid                = 1'b1;
                  next_state.addr_len   = len_eff;
                  next_state.addr_count = count_inc;
               end else if (cur_state.atyp == ATYP_DOMAIN && data_byte != 8'd0) begin
                  // domain length byte, not itself part of the address
                  next_state.addr_len   = data_byte;
                  next_state.addr_count = 8'd0;
               end
            end
            PHASE_PORT: begin
               next_state.port_count = port_count_inc;
               if (cur_state.port_count == 2'd0) begin
                  next_state.port = {data_byte, 8'd0};
               end else begin
                  next_state.port = cur_state.port | {8'd0, data_byte};
               end
            end
            default: next_state.phase = phase_in;
         endcase
      end
   end

   // result beat, showing the state after this byte
   always_comb begin
      rsp.parse_status    = phase_in;
      rsp.done_res        = (phase_in >= PHASE_OK) && (phase_in <= PHASE_BADDOMAIN);
      rsp.errored         = (phase_in >= PHASE_BADVER) && (phase_in <= PHASE_BADDOMAIN);
      rsp.command_code    = next_state.cmd;
      rsp.address_kind    = next_state.atyp;
      rsp.address_length  = next_state.addr_len;
      rsp.addr_byte_valid = avalid;
      rsp.addr_byte       = avalid ? data_byte : 8'd0;
      rsp.addr_position   = avalid ? count_eff : 8'd0;
      rsp.dest_port       = next_state.port;
   end

endmodule

// File: rtl/s5req_rsp_reg.sv
// result register between the parser logic and the result channel
// depends on s5req_pkg
module s5req_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  s5req_pkg::rsp_type rsp_next,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output s5req_pkg::rsp_type rsp_data,
   output logic               req_stall
);
   import s5req_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // hold while the taker stalls, otherwise free for a new beat
   assign req_stall = valid_ff && rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/socks5_request_byte_parser.sv
// top level of the socks5 request byte parser
// depends on s5req_pkg, s5req_step and s5req_rsp_reg
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------------
//   req_     | in        | req_valid / req_stall | data_byte, restart
//   rsp_     | out       | rsp_valid / rsp_stall | status, codes, address byte, port
//
// one byte per cycle while req_stall is low: each accepted beat updates the parser state
// and loads the result register in the same edge; the result shows in the cycle after
// reset is synchronous and active high; it clears the parser to expect version
// and empties the result register
// req_stall rises only while a result is held and rsp_stall is high, so the
// block keeps taking a beat every cycle while results drain
module socks5_request_byte_parser (
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   // result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_parse_status,
   output logic        rsp_done_res,
   output logic        rsp_errored,
   output logic [1:0]  rsp_command_code,
   output logic [2:0]  rsp_address_kind,
   output logic [7:0]  rsp_address_length,
   output logic        rsp_addr_byte_valid,
   output logic [7:0]  rsp_addr_byte,
   output logic [7:0]  rsp_addr_position,
   output logic [15:0] rsp_dest_port
);
   import s5req_pkg::*;

   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_next;
   rsp_type   rsp_data;
   logic      req_take;

   // a beat is taken when valid and not stalled
   assign req_take = req_valid && !req_stall;

   // parser state: phase, accepted codes, address length/count, port
   always_ff @(posedge clock) begin
      if (reset) begin
         // all zero, phase zero is expect version
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // per-byte decode and state update
   s5req_step u_step (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .restart    (req_restart),
      .next_state (state_in),
      .rsp        (rsp_next)
   );

   // result register, parts the two channels
   s5req_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_stall (req_stall)
   );

   // unpack the result beat onto its ports
   assign rsp_parse_status    = rsp_data.parse_status;
   assign rsp_done_res        = rsp_data.done_res;
   assign rsp_errored         = rsp_data.errored;
   assign rsp_command_code    = rsp_data.command_code;
   assign rsp_address_kind    = rsp_data.address_kind;
   assign rsp_address_length  = rsp_data.address_length;
   assign rsp_addr_byte_valid = rsp_data.addr_byte_valid;
   assign rsp_addr_byte       = rsp_data.addr_byte;
   assign rsp_addr_position   = rsp_data.addr_position;
   assign rsp_dest_port       = rsp_data.dest_port;

endmodule

// File: tb/socks5_request_byte_parser_tb.sv
`timescale 1ns / 100ps
// self-checking bench for socks5_request_byte_parser: byte beats in, one status beat out
// depends on s5req_pkg and the rtl top level; the parse tracker class predicts each status
module socks5_request_byte_parser_tb;
   import s5req_pkg::*;

   // bind has no name in the package
   localparam logic [7:0] CMD_BIND = 8'd2;
   localparam int unsigned RANDOM_BEATS = 1050;
   localparam int unsigned CYCLE_LIMIT = 400000;

   // ways a random request goes wrong
   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_VERSION,
      FLAW_COMMAND,
      FLAW_RESERVED,
      FLAW_ATYP,
      FLAW_EMPTY_DOMAIN,
      FLAW_CUT,
      FLAW_NOISE
   } request_flaw_e;

   // tracks the parser state beat by beat and holds the statuses still owed
   class parse_tracker;
      phase_type   phase;
      logic [1:0]  cmd;
      logic [2:0]  atyp;
      logic [7:0]  addr_len;
      logic [7:0]  addr_count;
      logic [1:0]  port_count;
      logic [15:0] port;
      rsp_type     owed_status[$];
      int unsigned failures;

      function new();
         failures = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase      = PHASE_VER;
         cmd        = '0;
         atyp       = '0;
         addr_len   = '0;
         addr_count = '0;
         port_count = '0;
         port       = '0;
      endfunction

      // advance the parser by one accepted byte and queue the status it shows
      function void take_byte(logic [7:0] b, logic restart);
         rsp_type    status;
         logic       avalid;
         logic [7:0] abyte;
         logic [7:0] apos;
         avalid = 1'b0;
         abyte  = '0;
         apos   = '0;
         if (restart) begin
            clear_parse();
         end else begin
            case (phase)
               PHASE_VER: begin
                  phase = (b == SOCKS_VERSION) ? PHASE_CMD : PHASE_BADVER;
               end
               PHASE_CMD: begin
                  if (b >= CMD_CONNECT && b <= CMD_UDP_ASSOC) begin
                     cmd   = b[1:0];
                     phase = PHASE_RSV;
                  end else begin
                     phase = PHASE_BADCMD;
                  end
               end
               PHASE_RSV: begin
                  phase = (b == RSV_VALUE) ? PHASE_ATYP : PHASE_BADRSV;
               end
               PHASE_ATYP: begin
                  if (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6) begin
                     atyp  = b[2:0];
                     phase = PHASE_ADDR;
                  end else begin
                     phase = PHASE_BADATYP;
                  end
               end
               PHASE_ADDR: begin
                  if (atyp == ATYP_DOMAIN && addr_len == 0) begin
                     // length byte of a domain, not an address byte itself
                     if (b == 0) begin
                        phase = PHASE_BADDOMAIN;
                     end else begin
                        addr_len   = b;
                        addr_count = '0;
                     end
                  end else if (atyp == ATYP_IPV4 || atyp == ATYP_IPV6 ||
                               atyp == ATYP_DOMAIN) begin
                     if (addr_len == 0) begin
                        addr_len   = (atyp == ATYP_IPV4) ? LEN_IPV4 : LEN_IPV6;
                        addr_count = '0;
                     end
                     avalid = 1'b1;
                     abyte  = b;
                     apos   = addr_count;
                     addr_count++;
                     if (addr_count == addr_len) phase = PHASE_PORT;
                  end else begin
                     phase = PHASE_BADATYP;
                  end
               end
               PHASE_PORT: begin
                  if (port_count == 0) port = {b, 8'h00};
                  else port = port | {8'h00, b};
                  port_count++;
                  if (port_count == PORT_BYTES) phase = PHASE_OK;
               end
               default: begin
                  // final phases absorb the byte
               end
            endcase
         end
         status.parse_status    = phase;
         status.done_res        = (phase >= PHASE_OK && phase <= PHASE_BADDOMAIN);
         status.errored         = (phase >= PHASE_BADVER && phase <= PHASE_BADDOMAIN);
         status.command_code    = cmd;
         status.address_kind    = atyp;
         status.address_length  = addr_len;
         status.addr_byte_valid = avalid;
         status.addr_byte       = abyte;
         status.addr_position   = apos;
         status.dest_port       = port;
         owed_status.push_back(status);
      endfunction

      function void note_failure(string why, rsp_type want, rsp_type got);
         failures++;
         if (failures <= 10) begin
            $display("%s: want st=%0d dn=%b er=%b cmd=%0d at=%0d len=%0d av=%b ab=%h ap=%0d pt=%h",
                     why, want.parse_status, want.done_res, want.errored, want.command_code,
                     want.address_kind, want.address_length, want.addr_byte_valid,
                     want.addr_byte, want.addr_position, want.dest_port);
            $display("%s: got  st=%0d dn=%b er=%b cmd=%0d at=%0d len=%0d av=%b ab=%h ap=%0d pt=%h",
                     why, got.parse_status, got.done_res, got.errored, got.command_code,
                     got.address_kind, got.address_length, got.addr_byte_valid,
                     got.addr_byte, got.addr_position, got.dest_port);
         end
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (owed_status.size() == 0) begin
            note_failure("status beat with nothing owed", got, got);
            return;
         end
         want = owed_status.pop_front();
         if (got.parse_status !== want.parse_status || got.done_res !== want.done_res ||
             got.errored !== want.errored || got.command_code !== want.command_code ||
             got.address_kind !== want.address_kind ||
             got.address_length !== want.address_length ||
             got.addr_byte_valid !== want.addr_byte_valid ||
             got.addr_byte !== want.addr_byte || got.addr_position !== want.addr_position ||
             got.dest_port !== want.dest_port)
            note_failure("status mismatch", want, got);
      endfunction

      function int unsigned owed();
         return owed_status.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_parse_status;
   logic        rsp_done_res;
   logic        rsp_errored;
   logic [1:0]  rsp_command_code;
   logic [2:0]  rsp_address_kind;
   logic [7:0]  rsp_address_length;
   logic        rsp_addr_byte_valid;
   logic [7:0]  rsp_addr_byte;
   logic [7:0]  rsp_addr_position;
   logic [15:0] rsp_dest_port;

   parse_tracker book = new();
   // when set, neither side idles nor stalls
   logic         quiet = 1'b0;
   int unsigned  beats_sent = 0;
   int unsigned  cycles = 0;

   socks5_request_byte_parser u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_parse_status    (rsp_parse_status),
      .rsp_done_res        (rsp_done_res),
      .rsp_errored         (rsp_errored),
      .rsp_command_code    (rsp_command_code),
      .rsp_address_kind    (rsp_address_kind),
      .rsp_address_length  (rsp_address_length),
      .rsp_addr_byte_valid (rsp_addr_byte_valid),
      .rsp_addr_byte       (rsp_addr_byte),
      .rsp_addr_position   (rsp_addr_position),
      .rsp_dest_port       (rsp_dest_port)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   // one request beat: idle a random number of cycles, then hold it until taken
   task automatic send_beat(input logic [7:0] b, input logic restart);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_restart   <= restart;
      // pre-edge values are seen here since the block updates on nonblocking writes
      do begin
         @(posedge clock);
      end while (req_stall);
      book.take_byte(b, restart);
      beats_sent++;
   endtask

   // restart, then a request that is mostly well formed with random content
   task automatic send_request();
      logic [7:0]    wire_bytes[$];
      request_flaw_e flaw;
      logic [7:0]    b;
      logic [2:0]    kind;
      int unsigned   n_addr;
      int unsigned   n_send;
      int            flaw_at;
      flaw_at = -1;
      flaw = ($urandom_range(0, 99) < 75) ? FLAW_NONE : request_flaw_e'($urandom_range(1, 7));
      quiet = ($urandom_range(0, 3) == 0);
      send_beat(8'($urandom), 1'b1);
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 8)) wire_bytes.push_back(8'($urandom));
      end else begin
         if (flaw == FLAW_VERSION) begin
            b = 8'($urandom_range(0, 254));
            if (b >= SOCKS_VERSION) b++;
            flaw_at = wire_bytes.size();
            wire_bytes.push_back(b);
         end else begin
            wire_bytes.push_back(SOCKS_VERSION);
         end
         if (flaw == FLAW_COMMAND) begin
            flaw_at = wire_bytes.size();
            wire_bytes.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(4, 255)));
         end else begin
            wire_bytes.push_back(8'($urandom_range(CMD_CONNECT, CMD_UDP_ASSOC)));
         end
         if (flaw == FLAW_RESERVED) begin
            flaw_at = wire_bytes.size();
            wire_bytes.push_back(8'($urandom_range(1, 255)));
         end else begin
            wire_bytes.push_back(RSV_VALUE);
         end
         if (flaw == FLAW_ATYP) begin
            do begin
               b = 8'($urandom);
            end while (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6);
            flaw_at = wire_bytes.size();
            wire_bytes.push_back(b);
         end else begin
            case ($urandom_range(0, 2))
               0:       kind = ATYP_IPV4;
               1:       kind = ATYP_DOMAIN;
               default: kind = ATYP_IPV6;
            endcase
            if (flaw == FLAW_EMPTY_DOMAIN) kind = ATYP_DOMAIN;
            wire_bytes.push_back(8'(kind));
            if (kind == ATYP_IPV4) begin
               n_addr = LEN_IPV4;
            end else if (kind == ATYP_IPV6) begin
               n_addr = LEN_IPV6;
            end else begin
               // mostly short names, now and then a long one up to the maximum
               case ($urandom_range(0, 19))
                  0:             n_addr = $urandom_range(0, 1) ? 255 : $urandom_range(128, 254);
                  1, 2, 3, 4, 5: n_addr = $urandom_range(13, 64);
                  default:       n_addr = $urandom_range(1, 12);
               endcase
               if (flaw == FLAW_EMPTY_DOMAIN) begin
                  n_addr  = 0;
                  flaw_at = wire_bytes.size();
               end
               wire_bytes.push_back(8'(n_addr));
            end
            repeat (n_addr) wire_bytes.push_back(8'($urandom));
            repeat (PORT_BYTES) wire_bytes.push_back(8'($urandom));
         end
         // a few bytes past the end land in a final phase
         repeat ($urandom_range(0, 2)) wire_bytes.push_back(8'($urandom));
      end
      n_send = wire_bytes.size();
      if (flaw_at >= 0 && flaw_at + 3 < n_send) n_send = flaw_at + 1 + $urandom_range(0, 2);
      if (flaw == FLAW_CUT) n_send = $urandom_range(1, wire_bytes.size() - 1);
      for (int i = 0; i < n_send; i++) send_beat(wire_bytes[i], 1'b0);
   endtask

   // result side: stall a random number of cycles before each status beat
   always begin : rsp_pacing
      int unsigned hold;
      @(negedge clock);
      hold = pick_gap();
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold) @(negedge clock);
      end
      rsp_stall <= 1'b0;
      do begin
         @(posedge clock);
      end while (reset || !rsp_valid);
   end

   // status beats are taken at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_status(rsp_type'({rsp_parse_status, rsp_done_res, rsp_errored,
                                      rsp_command_code, rsp_address_kind, rsp_address_length,
                                      rsp_addr_byte_valid, rsp_addr_byte, rsp_addr_position,
                                      rsp_dest_port}));
   end

   initial begin : stimulus
      int unsigned start;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bad version, then a restart out of a final phase with its byte ignored
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      // command zero
      send_beat(SOCKS_VERSION, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      // nonzero reserved byte after udp associate
      send_beat(SOCKS_VERSION, 1'b0);
      send_beat(CMD_UDP_ASSOC, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h55, 1'b1);
      // unknown address type
      send_beat(SOCKS_VERSION, 1'b0);
      send_beat(CMD_CONNECT, 1'b0);
      send_beat(RSV_VALUE, 1'b0);
      send_beat(8'h02, 1'b0);
      send_beat(8'hAA, 1'b1);
      // domain of length zero
      send_beat(SOCKS_VERSION, 1'b0);
      send_beat(CMD_BIND, 1'b0);
      send_beat(RSV_VALUE, 1'b0);
      send_beat({5'd0, ATYP_DOMAIN}, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      // one byte domain, all-ones address and port, then a byte absorbed after ok
      send_beat(SOCKS_VERSION, 1'b0);
      send_beat(CMD_BIND, 1'b0);
      send_beat(RSV_VALUE, 1'b0);
      send_beat({5'd0, ATYP_DOMAIN}, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h5A, 1'b0);

      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) send_request();

      @(negedge clock);
      req_valid <= 1'b0;
      while (book.owed() != 0) @(posedge clock);
      // the result register holds at most one beat, so a short drain is plenty
      repeat (4) @(posedge clock);
      if (book.failures == 0 && book.owed() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/s5req_pkg.sv
rtl/s5req_step.sv
rtl/s5req_rsp_reg.sv
rtl/socks5_request_byte_parser.sv
tb/socks5_request_byte_parser_tb.sv
